@@ rtl/tpcr_pkg.sv @@
`default_nettype none

package tpcr_pkg;

   // Fixed field widths
   localparam int HOLD_BITS  = 32;
   localparam int NOW_BITS   = 32;
   localparam int PCT_BITS   = 7;
   localparam int DIR_BITS   = 2;
   localparam int PULSE_BITS = 16;

   // Default parameter values
   localparam int TIME_BITS_DEF     = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Target numerator: max*(100-p) + min*p is at most 65535*100 < 2^23
   localparam int NUM_BITS = 23;
   localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

   // x/25 == (x * RECIP25) >> RECIP25_SHIFT for any x below 2^30
   localparam int RECIP25_BITS  = 28;
   localparam logic [RECIP25_BITS-1:0] RECIP25 = 28'd171798692;
   localparam int RECIP25_SHIFT = 32;

   // x/5 == (x * RECIP5) >> RECIP_SHIFT for any 32-bit x
   localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 34;

   // Configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_PULSE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_PULSE = 1'd1;
   localparam logic [PULSE_BITS-1:0] MIN_PULSE_RESET = 16'd5000;
   localparam logic [PULSE_BITS-1:0] MAX_PULSE_RESET = 16'd50000;

   // Operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   // Direction codes
   localparam logic [DIR_BITS-1:0] DIR_FWD      = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_REV      = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_OTHER    = 2'd2;
   localparam logic [DIR_BITS-1:0] DIR_RESERVED = 2'd3;

   typedef struct packed {
      logic                 operation;
      logic [NOW_BITS-1:0]  now_us;
      logic [PCT_BITS-1:0]  speed_percent;
      logic [DIR_BITS-1:0]  direction_code;
   } req_item_type;

   // Controller to datapath
   typedef struct packed {
      logic item_load;
      logic calc;
      logic update;
      logic mul;
      logic div_start;
      logic apply;
      logic out_load;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_is_cmd;
      logic div_done;
      logic out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

@@ rtl/tpcr_if.sv @@
`default_nettype none

// Input item channel
interface tpcr_req_if;
   import tpcr_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [NOW_BITS-1:0] now_us;
   logic [PCT_BITS-1:0] speed_percent;
   logic [DIR_BITS-1:0] direction_code;

   modport source (output valid, operation, now_us, speed_percent, direction_code,
                   input ready);
   modport sink   (input valid, operation, now_us, speed_percent, direction_code,
                   output ready);
endinterface

// Result channel
interface tpcr_rsp_if;
   import tpcr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 pin_one;
   logic                 pin_two;
   logic                 pin_three;
   logic [HOLD_BITS-1:0] hold_now;

   modport source (output valid, pin_one, pin_two, pin_three, hold_now, input ready);
   modport sink   (input valid, pin_one, pin_two, pin_three, hold_now, output ready);
endinterface

// Configuration write channel
interface tpcr_csr_if;
   import tpcr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [PULSE_BITS-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/tpcr_div.sv @@
`default_nettype none

// Divide (num << SHIFT) by 100 with reciprocal multiplies by 1/25:
// num = 25*q + r, result = (q << (SHIFT-2)) + floor((r << (SHIFT-2)) / 25).
// start passes through stage_ff[0..2] into done_ff; done rises with quotient.
module tpcr_div #(
   parameter int SHIFT = tpcr_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [tpcr_pkg::NUM_BITS-1:0]        num,
   output logic                                      done,
   output logic [tpcr_pkg::HOLD_BITS-1:0]            quotient
);
   import tpcr_pkg::*;

   localparam int Q_BITS = NUM_BITS - 4;
   localparam int R_BITS = 5;
   localparam int P1_W   = NUM_BITS + RECIP25_BITS;
   localparam int Y_W    = R_BITS + SHIFT - 2;
   localparam int P2_W   = Y_W + RECIP25_BITS;
   localparam int F_W    = P2_W - RECIP25_SHIFT;
   localparam int SUM_W  = Q_BITS + SHIFT - 1;

   logic [2:0]           stage_ff;
   logic                 done_ff;
   logic [NUM_BITS-1:0]  num_ff;
   logic [P1_W-1:0]      p1_ff;
   logic [Q_BITS-1:0]    q_ff;
   logic [R_BITS-1:0]    r_ff;
   logic [P2_W-1:0]      p2_ff;
   logic [HOLD_BITS-1:0] quot_ff;

   logic [Q_BITS-1:0]    q_in;
   logic [NUM_BITS-1:0]  q25;
   logic [R_BITS-1:0]    r_in;
   logic [Y_W-1:0]       y_in;
   logic [F_W-1:0]       frac;
   logic [SUM_W-1:0]     sum_in;

   // Whole part num/25 and remainder
   assign q_in = p1_ff[P1_W-1:RECIP25_SHIFT];
   assign q25  = (NUM_BITS'(q_in) << 4) + (NUM_BITS'(q_in) << 3) + NUM_BITS'(q_in);
   assign r_in = R_BITS'(num_ff - q25);

   // Fraction from the remainder, then recombine
   assign y_in   = Y_W'(r_ff) << (SHIFT - 2);
   assign frac   = p2_ff[P2_W-1:RECIP25_SHIFT];
   assign sum_in = (SUM_W'(q_ff) << (SHIFT - 2)) + SUM_W'(frac);

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= {stage_ff[1:0], start};
         done_ff  <= stage_ff[2];
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         p1_ff  <= num * RECIP25;
      end
      if (stage_ff[0]) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
      if (stage_ff[1]) p2_ff <= y_in * RECIP25;
      if (stage_ff[2]) quot_ff <= HOLD_BITS'(sum_in);
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

@@ rtl/tpcr_dp.sv @@
`default_nettype none

module tpcr_dp #(
   parameter int TIME_BITS     = tpcr_pkg::TIME_BITS_DEF,
   parameter int FRACTION_BITS = tpcr_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tpcr_pkg::ctrl_cmd_type               cmd,
   output tpcr_pkg::ctrl_stat_type                   stat,
   input  wire tpcr_pkg::req_item_type               req_item,
   input  wire logic                                 cfg_we,
   input  wire logic [tpcr_pkg::CSR_INDEX_BITS-1:0]  cfg_index,
   input  wire logic [tpcr_pkg::PULSE_BITS-1:0]      cfg_data,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic [2:0]                                rsp_pins,
   output logic [tpcr_pkg::HOLD_BITS-1:0]            rsp_hold
);
   import tpcr_pkg::*;

   localparam int PART_W = HOLD_BITS + 4;
   localparam int CMP_W  = (TIME_BITS > PART_W) ? TIME_BITS : PART_W;
   localparam int PSHIFT = FRACTION_BITS + 2;
   localparam logic [PART_W-1:0] ONE_M1 = PART_W'((64'd1 << PSHIFT) - 64'd1);
   localparam logic [HOLD_BITS-1:0] UP_STEP =
      HOLD_BITS'(((64'd1 << FRACTION_BITS) + 64'd20) / 64'd40);
   localparam int PROD_W = 62;
   localparam int STEP_W = PROD_W - RECIP_SHIFT;

   // Configuration
   logic [PULSE_BITS-1:0] min_ff, max_ff;

   // Block state
   logic [2:0]           pins_ff;
   logic [HOLD_BITS-1:0] hold_ff;
   logic [HOLD_BITS-1:0] target_ff;
   logic [DIR_BITS-1:0]  dir_ff;
   logic                 running_ff;
   logic [TIME_BITS-1:0] first_ff, third_ff;

   // Latched item
   logic                 op_ff;
   logic [NOW_BITS-1:0]  now_ff;
   logic [PCT_BITS-1:0]  pct_ff;
   logic [DIR_BITS-1:0]  dir_in_ff;

   // Stage registers
   logic [NUM_BITS-1:0]  num_ff;
   logic [TIME_BITS-1:0] td_ff;
   logic [CMP_W-1:0]     f1_ff, f3_ff, f4_ff, f6_ff, f7_ff, f9_ff, c3_ff, c7_ff;
   logic [PROD_W-1:0]    prod_ff;

   // Result register
   logic                 out_valid_ff;
   logic [2:0]           out_pins_ff;
   logic [HOLD_BITS-1:0] out_hold_ff;

   // Command numerator
   logic [PCT_BITS-1:0]  pct_sat;
   logic [NUM_BITS-1:0]  prod_max, prod_min, num_in;

   // Hold multiples
   logic [PART_W-1:0]    h1, h3, h4, h6, h7, h9;
   logic [TIME_BITS-1:0] now_t, td_in;

   // Down step
   logic [HOLD_BITS:0]   h_plus;
   logic [29:0]          x_div8;
   logic [PROD_W-1:0]    prod_in;
   logic [STEP_W-1:0]    step;
   logic [HOLD_BITS:0]   up_sum;

   // Phase update
   logic                 fwd, drive, fs_hit;
   logic [1:0]           a_idx, c_idx;
   logic [CMP_W-1:0]     td_a, td_b;
   logic [2:0]           pins_nx;
   logic [TIME_BITS-1:0] first_nx, third_nx;
   logic [HOLD_BITS-1:0] hold_nx;

   // Divider
   logic                 div_done;
   logic [HOLD_BITS-1:0] div_q;
   logic [DIR_BITS-1:0]  dir_norm;

   tpcr_div #(.SHIFT(FRACTION_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Status
   assign stat.req_is_cmd = (req_item.operation == OP_CMD);
   assign stat.div_done   = div_done;
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   // Target numerator with saturated percent
   assign pct_sat  = (pct_ff > PCT_FULL) ? PCT_FULL : pct_ff;
   assign prod_max = max_ff * (PCT_FULL - pct_sat);
   assign prod_min = min_ff * pct_sat;
   assign num_in   = prod_max + prod_min;

   // Multiples of the hold by shifts, adds and a subtract
   assign h1 = PART_W'(hold_ff);
   assign h3 = h1 + (h1 << 1);
   assign h4 = h1 << 2;
   assign h6 = h3 << 1;
   assign h7 = (h1 << 3) - h1;
   assign h9 = (h1 << 3) + h1;

   assign now_t = TIME_BITS'(now_ff);
   assign td_in = now_t - first_ff;

   // ceil(h/40) = floor(floor((h+39)/8)/5)
   assign h_plus  = {1'b0, hold_ff} + (HOLD_BITS+1)'(39);
   assign x_div8  = h_plus[HOLD_BITS:3];
   assign prod_in = x_div8 * RECIP5;
   assign step    = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign up_sum  = {1'b0, hold_ff} + {1'b0, UP_STEP};

   assign dir_norm = (dir_in_ff == DIR_RESERVED) ? DIR_OTHER : dir_in_ff;

   // Phase checks in order A, B, C, then the ramp
   always_comb begin
      fwd      = (dir_ff == DIR_FWD);
      drive    = fwd || (dir_ff == DIR_REV);
      a_idx    = fwd ? 2'd2 : 2'd0;
      c_idx    = fwd ? 2'd0 : 2'd2;
      pins_nx  = pins_ff;
      first_nx = first_ff;
      third_nx = third_ff;
      fs_hit   = 1'b0;
      td_a     = CMP_W'(td_ff);
      if (drive) begin
         // Phase A
         if (pins_ff[a_idx]) begin
            if (td_a > f4_ff) pins_nx[a_idx] = 1'b0;
         end else if (td_a > f9_ff) begin
            pins_nx[a_idx] = 1'b1;
            first_nx       = now_t;
            fs_hit         = 1'b1;
         end
      end
      td_b = fs_hit ? '0 : td_a;
      if (drive) begin
         // Phase B
         if (pins_ff[1]) begin
            if (td_b > f7_ff || td_b < c3_ff) pins_nx[1] = 1'b0;
         end else if (td_b > f3_ff && td_b < c7_ff) begin
            pins_nx[1] = 1'b1;
         end
         // Phase C
         if (pins_ff[c_idx]) begin
            if (td_b > f1_ff && third_ff < first_nx) pins_nx[c_idx] = 1'b0;
         end else if (td_b > f6_ff) begin
            pins_nx[c_idx] = 1'b1;
            third_nx       = now_t;
         end
      end
      // Ramp toward target
      hold_nx = hold_ff;
      if (hold_ff > target_ff) begin
         hold_nx = hold_ff - HOLD_BITS'(step);
      end else if (hold_ff < target_ff) begin
         hold_nx = up_sum[HOLD_BITS] ? '1 : up_sum[HOLD_BITS-1:0];
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= MIN_PULSE_RESET;
         max_ff       <= MAX_PULSE_RESET;
         pins_ff      <= '0;
         hold_ff      <= '0;
         target_ff    <= '0;
         dir_ff       <= DIR_OTHER;
         running_ff   <= 1'b0;
         first_ff     <= '0;
         third_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            unique case (cfg_index)
               REG_MIN_PULSE: min_ff <= cfg_data;
               REG_MAX_PULSE: max_ff <= cfg_data;
            endcase
         end
         if (cmd.update && running_ff && op_ff == OP_TICK) begin
            pins_ff  <= pins_nx;
            first_ff <= first_nx;
            third_ff <= third_nx;
            hold_ff  <= hold_nx;
         end
         if (cmd.apply) begin
            target_ff  <= div_q;
            running_ff <= 1'b1;
            if (dir_norm != dir_ff) begin
               hold_ff <= div_q >> 1;
               dir_ff  <= dir_norm;
               if (dir_norm == DIR_FWD) pins_ff[0] <= 1'b1;
               else if (dir_norm == DIR_REV) pins_ff[2] <= 1'b1;
            end
         end
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_ff     <= req_item.operation;
         now_ff    <= req_item.now_us;
         pct_ff    <= req_item.speed_percent;
         dir_in_ff <= req_item.direction_code;
      end
      if (cmd.mul) num_ff <= num_in;
      if (cmd.calc) begin
         td_ff   <= td_in;
         f1_ff   <= CMP_W'(h1 >> PSHIFT);
         f3_ff   <= CMP_W'(h3 >> PSHIFT);
         f4_ff   <= CMP_W'(h4 >> PSHIFT);
         f6_ff   <= CMP_W'(h6 >> PSHIFT);
         f7_ff   <= CMP_W'(h7 >> PSHIFT);
         f9_ff   <= CMP_W'(h9 >> PSHIFT);
         c3_ff   <= CMP_W'((h3 + ONE_M1) >> PSHIFT);
         c7_ff   <= CMP_W'((h7 + ONE_M1) >> PSHIFT);
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         out_pins_ff <= pins_ff;
         out_hold_ff <= hold_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pins  = out_pins_ff;
   assign rsp_hold  = out_hold_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("result beat overwritten before it was taken");

   a_running_sticks: assert property (@(posedge clock) disable iff (reset)
      running_ff |=> running_ff)
      else $error("running flag dropped without reset");

   a_dir_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> (dir_ff != DIR_RESERVED))
      else $error("reserved direction code stored");
`endif

endmodule

`default_nettype wire

@@ rtl/tpcr_ctrl.sv @@
`default_nettype none

module tpcr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire tpcr_pkg::ctrl_stat_type stat,
   output tpcr_pkg::ctrl_cmd_type       cmd
);
   import tpcr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_UPDATE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_APPLY,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = stat.req_is_cmd ? ST_MUL : ST_CALC;
         end
         ST_CALC:     state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DONE;
         ST_MUL:      state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (stat.div_done) state_in = ST_APPLY;
         end
         ST_APPLY:    state_in = ST_DONE;
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command decode
   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.item_load = (state_ff == ST_IDLE) && req_valid;
   assign cmd.calc      = (state_ff == ST_CALC);
   assign cmd.update    = (state_ff == ST_UPDATE);
   assign cmd.mul       = (state_ff == ST_MUL);
   assign cmd.div_start = (state_ff == ST_DIV_GO);
   assign cmd.apply     = (state_ff == ST_APPLY);
   assign cmd.out_load  = (state_ff == ST_DONE) && stat.out_free;

`ifndef SYNTHESIS
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside of its wait state");
`endif

endmodule

`default_nettype wire

@@ rtl/three_phase_commutation_ramp_core.sv @@
`default_nettype none

// Items are taken one at a time, only in idle. Tick: calc, update, then done
// loads the result beat. Command: mul, div go, div wait, apply, then done; the
// target hold comes from the four-stage reciprocal-multiply divide by 100.
// A result waiting on rsp holds off only the next item's final output load.
// Synchronous active-high reset: pins low, hold and target zero, direction other,
// not running, timer starts zero, min/max pulse registers 5000/50000.
module three_phase_commutation_ramp_core #(
   parameter int TIME_BITS     = tpcr_pkg::TIME_BITS_DEF,
   parameter int FRACTION_BITS = tpcr_pkg::FRACTION_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tpcr_req_if.sink    req_ch,
   tpcr_rsp_if.source  rsp_ch,
   tpcr_csr_if.sink    csr_ch
);
   import tpcr_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   req_item_type  req_item;
   logic          req_ready;
   logic [2:0]    rsp_pins;

   assign req_item.operation      = req_ch.operation;
   assign req_item.now_us         = req_ch.now_us;
   assign req_item.speed_percent  = req_ch.speed_percent;
   assign req_item.direction_code = req_ch.direction_code;
   assign req_ch.ready            = req_ready;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   tpcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpcr_dp #(
      .TIME_BITS     (TIME_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .cfg_we    (csr_ch.valid),
      .cfg_index (csr_ch.index),
      .cfg_data  (csr_ch.wdata),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_pins  (rsp_pins),
      .rsp_hold  (rsp_ch.hold_now)
   );

   assign rsp_ch.pin_one   = rsp_pins[0];
   assign rsp_ch.pin_two   = rsp_pins[1];
   assign rsp_ch.pin_three = rsp_pins[2];

endmodule

`default_nettype wire
